// ===== rtl/button_autorepeat_generator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Button autorepeat generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTOREPEAT_GENERATOR_UNIT_MACROS_SVH
`define BUTTON_AUTOREPEAT_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BARG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BARG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/barg_pkg.sv =====
// ----------------------------------------------------------------------------
// Button autorepeat generator package
// Shared constants and types for the configuration block and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package barg_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_STAGES_DEF    = 4;
  localparam int DURATION_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COUNT_W    = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_BASE  = 3'd1;

  // Field positions inside a stage word.
  localparam int DELAY_LSB = 0;
  localparam int ON_LSB    = 16;
  localparam int OFF_LSB   = 32;

  // Reset contents of stage 0 and of the stage count.
  localparam logic [15:0]        STAGE0_DELAY_RST = 16'd1000;
  localparam logic [15:0]        STAGE0_ON_RST    = 16'd100;
  localparam logic [15:0]        STAGE0_OFF_RST   = 16'd900;
  localparam logic [COUNT_W-1:0] STAGE_COUNT_RST  = 3'd1;

  // Stage index codes: idle, first delay running, repeating from stage 0.
  localparam logic [COUNT_W-1:0] IDX_IDLE   = 3'd0;
  localparam logic [COUNT_W-1:0] IDX_FIRST  = 3'd1;
  localparam logic [COUNT_W-1:0] IDX_REPEAT = 3'd2;

  // Outcome of one processed word.
  typedef struct packed {
    logic valid;
    logic level;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/barg_cfg.sv =====
// ----------------------------------------------------------------------------
// Button autorepeat configuration registers
// Holds the stage count and the per-stage delay, on and off times.
// ----------------------------------------------------------------------------
`default_nettype none

module barg_cfg
  import barg_pkg::*;
#(
  parameter int MAX_STAGES    = MAX_STAGES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]                       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]                      cfg_data_i,
  output logic [COUNT_W-1:0]                              stage_cnt_o,
  output logic [MAX_STAGES-1:0][DURATION_BITS-1:0]        delay_o,
  output logic [MAX_STAGES-1:0][DURATION_BITS-1:0]        on_o,
  output logic [MAX_STAGES-1:0][DURATION_BITS-1:0]        off_o
);

  logic [COUNT_W-1:0] count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= STAGE_COUNT_RST;
    end else if (cfg_valid_i && cfg_index_i == CFG_STAGE_COUNT) begin
      count_q <= cfg_data_i[COUNT_W-1:0];
    end
  end

  // A zero count behaves as one stage, anything past the array as the full array.
  always_comb begin
    stage_cnt_o = count_q;
    if (count_q == '0) begin
      stage_cnt_o = 3'd1;
    end
    if (count_q > COUNT_W'(MAX_STAGES)) begin
      stage_cnt_o = COUNT_W'(MAX_STAGES);
    end
  end

  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_stage
    logic [DURATION_BITS-1:0] delay_q;
    logic [DURATION_BITS-1:0] on_q;
    logic [DURATION_BITS-1:0] off_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        if (k == 0) begin
          delay_q <= STAGE0_DELAY_RST[DURATION_BITS-1:0];
          on_q    <= STAGE0_ON_RST[DURATION_BITS-1:0];
          off_q   <= STAGE0_OFF_RST[DURATION_BITS-1:0];
        end else begin
          delay_q <= '0;
          on_q    <= '0;
          off_q   <= '0;
        end
      end else if (cfg_valid_i && cfg_index_i == CFG_STAGE_BASE + CFG_IDX_W'(k)) begin
        delay_q <= cfg_data_i[DELAY_LSB +: DURATION_BITS];
        on_q    <= cfg_data_i[ON_LSB +: DURATION_BITS];
        off_q   <= cfg_data_i[OFF_LSB +: DURATION_BITS];
      end
    end

    assign delay_o[k] = delay_q;
    assign on_o[k]    = on_q;
    assign off_o[k]   = off_q;
  end

endmodule

`default_nettype wire

// ===== rtl/barg_engine.sv =====
// ----------------------------------------------------------------------------
// Button autorepeat engine
// Change detector, stage timer and toggle timer, updated once per word.
// ----------------------------------------------------------------------------
`default_nettype none

module barg_engine
  import barg_pkg::*;
#(
  parameter int MAX_STAGES    = MAX_STAGES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       fire_i,
  input  wire logic                                       level_i,
  input  wire logic [COUNT_W-1:0]                         stage_cnt_i,
  input  wire logic [MAX_STAGES-1:0][DURATION_BITS-1:0]   delay_i,
  input  wire logic [MAX_STAGES-1:0][DURATION_BITS-1:0]   on_i,
  input  wire logic [MAX_STAGES-1:0][DURATION_BITS-1:0]   off_i,
  output result_t                                         res_o
);

  logic                     last_q, last_d;
  logic                     seen_q, seen_d;
  logic [COUNT_W-1:0]       idx_q, idx_d;
  logic [DURATION_BITS-1:0] st_tmr_q, st_tmr_d;
  logic                     st_arm_q, st_arm_d;
  logic [DURATION_BITS-1:0] tg_tmr_q, tg_tmr_d;
  logic                     tg_arm_q, tg_arm_d;
  logic                     tg_next_q, tg_next_d;
  logic                     skip_stage, skip_toggle;
  logic [COUNT_W-1:0]       cur;

  function automatic logic [DURATION_BITS-1:0] pick(
    input logic [MAX_STAGES-1:0][DURATION_BITS-1:0] arr,
    input logic [COUNT_W-1:0]                       sel
  );
    logic [DURATION_BITS-1:0] r;
    r = '0;
    for (int k = 0; k < MAX_STAGES; k++) begin
      if (sel == COUNT_W'(k)) begin
        r = arr[k];
      end
    end
    return r;
  endfunction

  // A zero duration still takes one tick.
  function automatic logic [DURATION_BITS-1:0] dur_fix(input logic [DURATION_BITS-1:0] d);
    return (d == '0) ? DURATION_BITS'(1) : d;
  endfunction

  // Stage whose on and off times apply, held within the stages in use.
  function automatic logic [COUNT_W-1:0] cur_stage(
    input logic [COUNT_W-1:0] idx,
    input logic [COUNT_W-1:0] cnt
  );
    logic [COUNT_W-1:0] s;
    s = (idx >= IDX_REPEAT) ? idx - IDX_REPEAT : '0;
    if (s > cnt - 3'd1) begin
      s = cnt - 3'd1;
    end
    return s;
  endfunction

  always_comb begin
    last_d      = last_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    st_tmr_d    = st_tmr_q;
    st_arm_d    = st_arm_q;
    tg_tmr_d    = tg_tmr_q;
    tg_arm_d    = tg_arm_q;
    tg_next_d   = tg_next_q;
    skip_stage  = 1'b0;
    skip_toggle = 1'b0;
    res_o       = '0;
    cur         = '0;

    // Level changes come first; the very first word always counts as a change.
    if (!seen_q || level_i != last_q) begin
      seen_d = 1'b1;
      last_d = level_i;
      if (level_i) begin
        if (idx_q == IDX_IDLE) begin
          st_tmr_d    = dur_fix(pick(delay_i, IDX_IDLE));
          st_arm_d    = 1'b1;
          idx_d       = IDX_FIRST;
          skip_stage  = 1'b1;
          res_o.valid = 1'b1;
          res_o.level = 1'b1;
        end
      end else begin
        st_arm_d    = 1'b0;
        st_tmr_d    = '0;
        tg_arm_d    = 1'b0;
        tg_tmr_d    = '0;
        tg_next_d   = 1'b0;
        idx_d       = IDX_IDLE;
        res_o.valid = 1'b1;
        res_o.level = 1'b0;
      end
    end

    if (st_arm_d && !skip_stage) begin
      st_tmr_d = st_tmr_d - DURATION_BITS'(1);
      if (st_tmr_d == '0) begin
        st_arm_d = 1'b0;
        if (idx_d < stage_cnt_i) begin
          st_tmr_d = dur_fix(pick(delay_i, idx_d));
          st_arm_d = 1'b1;
        end
        if (idx_d <= stage_cnt_i) begin
          idx_d = idx_d + 3'd1;
        end
        // End of the first delay: repetition starts with an off phase.
        if (idx_d == IDX_REPEAT) begin
          tg_tmr_d    = dur_fix(pick(off_i, cur_stage(idx_d, stage_cnt_i)));
          tg_arm_d    = 1'b1;
          tg_next_d   = 1'b1;
          skip_toggle = 1'b1;
          res_o.valid = 1'b1;
          res_o.level = 1'b0;
        end
      end
    end

    if (tg_arm_d && !skip_toggle) begin
      tg_tmr_d = tg_tmr_d - DURATION_BITS'(1);
      if (tg_tmr_d == '0) begin
        cur         = cur_stage(idx_d, stage_cnt_i);
        res_o.valid = 1'b1;
        res_o.level = tg_next_d;
        tg_tmr_d    = tg_next_d ? dur_fix(pick(on_i, cur)) : dur_fix(pick(off_i, cur));
        tg_next_d   = !tg_next_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      seen_q    <= 1'b0;
      idx_q     <= IDX_IDLE;
      st_tmr_q  <= '0;
      st_arm_q  <= 1'b0;
      tg_tmr_q  <= '0;
      tg_arm_q  <= 1'b0;
      tg_next_q <= 1'b0;
    end else if (fire_i) begin
      last_q    <= last_d;
      seen_q    <= seen_d;
      idx_q     <= idx_d;
      st_tmr_q  <= st_tmr_d;
      st_arm_q  <= st_arm_d;
      tg_tmr_q  <= tg_tmr_d;
      tg_arm_q  <= tg_arm_d;
      tg_next_q <= tg_next_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_autorepeat_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Button autorepeat generator
// Turns sampled button levels into a press, release and autorepeat stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i, in_stall_o, level_i): one word per timer tick,
//   carrying the sampled button level. Output channel (out_valid_o,
//   out_stall_i, out_level_o): zero or one word per input word, the new
//   output level. Configuration channel (cfg_valid_i, cfg_ready_o,
//   cfg_index_i, cfg_data_i): index 0 is the stage count, indexes 1 to 4
//   the stage words; ready is always high. Writes are to go in only while
//   idle; the block itself leaves this unchecked. Each word passes an input
//   register and then a single update of the timers into the output
//   register, from which it is taken. One word is accepted every cycle
//   while in_stall_o is low.
//   When the receiver stalls, the output register holds its word, one more
//   input word waits in the input register, and then in_stall_o rises.
//   Reset clears the timers and the change detector, sets the stage count
//   to one and restores the stage 0 times (delay 1000, on 100, off 900).
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_autorepeat_generator_unit_macros.svh"

module button_autorepeat_generator_unit
  import barg_pkg::*;
#(
  parameter int MAX_STAGES    = MAX_STAGES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       out_level_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic                                      in_valid_q;
  logic                                      level_q;
  logic                                      out_valid_q;
  logic                                      out_level_q;
  logic                                      fire;
  result_t                                   res;
  logic [COUNT_W-1:0]                        stage_cnt;
  logic [MAX_STAGES-1:0][DURATION_BITS-1:0]  delay;
  logic [MAX_STAGES-1:0][DURATION_BITS-1:0]  on_time;
  logic [MAX_STAGES-1:0][DURATION_BITS-1:0]  off_time;

  // The held word is processed whenever the output register can take a result.
  assign fire       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      level_q <= level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_level_q <= res.level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_level_o = out_level_q;

  barg_cfg #(
    .MAX_STAGES    (MAX_STAGES),
    .DURATION_BITS (DURATION_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stage_cnt_o (stage_cnt),
    .delay_o     (delay),
    .on_o        (on_time),
    .off_o       (off_time)
  );

  barg_engine #(
    .MAX_STAGES    (MAX_STAGES),
    .DURATION_BITS (DURATION_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .level_i     (level_q),
    .stage_cnt_i (stage_cnt),
    .delay_i     (delay),
    .on_i        (on_time),
    .off_i       (off_time),
    .res_o       (res)
  );

  `BARG_ASSERT_SAME(a_no_overwrite, out_valid_q && out_stall_i, !fire, "result overwritten")
  `BARG_ASSERT_NEXT(a_result_shown, fire && res.valid, out_valid_q, "result not presented")
  `BARG_ASSERT_NEXT(a_word_held, in_stall_o, in_valid_q && $stable(level_q), "held word lost")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button autorepeat generator testbench
// Drives sampled button levels through the input channel and predicts the
// press, release and autorepeat words word by word. Every word taken from
// the output channel is checked in order against the prediction. The stage
// registers are rewritten between phases, and both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module testbench;
  import barg_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_LIMIT = 60000;
  localparam int unsigned PIPE_SLACK   = 6;
  localparam int unsigned MAX_IDLE     = 17;
  localparam int unsigned LAST_STAGE   = MAX_STAGES_DEF - 1;
  localparam int          STAGE_IDX_W  = $clog2(MAX_STAGES_DEF);
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_STAGE = CFG_STAGE_BASE + CFG_IDX_W'(LAST_STAGE);
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP  = {CFG_IDX_W{1'b1}};

  typedef struct {
    bit          level;
    int unsigned gap;
    bit          drain_first;
  } level_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  level_i     = 1'b0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  out_level_o;
  logic                  cfg_ready_o;

  button_autorepeat_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_level_o (out_level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  level_word_t pending_levels[$];
  bit          expected_levels[$];
  int unsigned mismatch_count  = 0;
  int unsigned cfg_write_count = 0;
  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  bit          level_taken  = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned idle_run   = 0;
  int unsigned stall_left = 0;

  // Predicted copy of the configuration and of the generator state.
  bit [COUNT_W-1:0]    stage_count_reg;
  bit [CFG_DATA_W-1:0] stage_word_reg [MAX_STAGES_DEF];
  bit                  prev_level;
  bit                  seen_level;
  bit [COUNT_W-1:0]    stage_pos;
  bit [15:0]           hold_timer;
  bit                  hold_armed;
  bit [15:0]           blink_timer;
  bit                  blink_armed;
  bit                  blink_next;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void reset_autorepeat();
    stage_count_reg = STAGE_COUNT_RST;
    foreach (stage_word_reg[i]) stage_word_reg[i] = '0;
    stage_word_reg[0][DELAY_LSB +: 16] = STAGE0_DELAY_RST;
    stage_word_reg[0][ON_LSB +: 16]    = STAGE0_ON_RST;
    stage_word_reg[0][OFF_LSB +: 16]   = STAGE0_OFF_RST;
    prev_level  = 1'b0;
    seen_level  = 1'b0;
    stage_pos   = IDX_IDLE;
    hold_timer  = '0;
    hold_armed  = 1'b0;
    blink_timer = '0;
    blink_armed = 1'b0;
    blink_next  = 1'b0;
  endfunction

  function automatic void write_autorepeat(input bit [CFG_IDX_W-1:0] idx,
                                           input bit [CFG_DATA_W-1:0] data);
    if (idx == CFG_STAGE_COUNT) stage_count_reg = data[COUNT_W-1:0];
    else if (idx >= CFG_STAGE_BASE && idx <= CFG_LAST_STAGE)
      stage_word_reg[STAGE_IDX_W'(idx - CFG_STAGE_BASE)] = data;
  endfunction

  function automatic int unsigned stages_in_use();
    int unsigned n;
    n = int'(stage_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_STAGES_DEF) n = MAX_STAGES_DEF;
    return n;
  endfunction

  // A zero duration behaves as one tick.
  function automatic bit [15:0] span(input int unsigned stage, input int unsigned lsb);
    bit [15:0] d;
    d = stage_word_reg[STAGE_IDX_W'(stage)][lsb +: 16];
    return (d == 0) ? 16'd1 : d;
  endfunction

  function automatic int unsigned repeat_stage();
    int unsigned n;
    int unsigned s;
    n = stages_in_use();
    s = (stage_pos >= IDX_REPEAT) ? int'(stage_pos - IDX_REPEAT) : 0;
    if (s > n - 1) s = n - 1;
    return s;
  endfunction

  function automatic void load_blink();
    int unsigned s;
    s = repeat_stage();
    blink_timer = blink_next ? span(s, ON_LSB) : span(s, OFF_LSB);
    blink_armed = 1'b1;
  endfunction

  // Returns one when the step starts repetition, which emits an off word.
  function automatic bit next_stage();
    int unsigned n;
    n = stages_in_use();
    if (stage_pos < n) begin
      hold_timer = span(int'(stage_pos), DELAY_LSB);
      hold_armed = 1'b1;
    end
    if (stage_pos <= n) stage_pos++;
    if (stage_pos == IDX_REPEAT) begin
      blink_next = 1'b0;
      load_blink();
      blink_next = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One timer tick: level change first, then the stage timer, then the toggle.
  function automatic bit tick_autorepeat(input bit lvl, output bit emitted);
    bit skip_hold;
    bit skip_blink;
    bit val;
    skip_hold  = 1'b0;
    skip_blink = 1'b0;
    val        = 1'b0;
    emitted    = 1'b0;
    if (!seen_level || lvl != prev_level) begin
      seen_level = 1'b1;
      prev_level = lvl;
      if (lvl) begin
        if (stage_pos == IDX_IDLE) begin
          if (next_stage()) skip_blink = 1'b1;
          skip_hold = 1'b1;
          emitted   = 1'b1;
          val       = 1'b1;
        end
      end else begin
        hold_armed  = 1'b0;
        hold_timer  = '0;
        blink_armed = 1'b0;
        blink_timer = '0;
        blink_next  = 1'b0;
        stage_pos   = IDX_IDLE;
        emitted     = 1'b1;
        val         = 1'b0;
      end
    end
    if (hold_armed && !skip_hold) begin
      hold_timer--;
      if (hold_timer == 0) begin
        hold_armed = 1'b0;
        if (next_stage()) begin
          skip_blink = 1'b1;
          emitted    = 1'b1;
          val        = 1'b0;
        end
      end
    end
    if (blink_armed && !skip_blink) begin
      blink_timer--;
      if (blink_timer == 0) begin
        emitted = 1'b1;
        val     = blink_next;
        load_blink();
        blink_next ^= 1'b1;
      end
    end
    return val;
  endfunction

  function automatic int unsigned idle_draw(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MAX_IDLE);
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
  endfunction

  // Accepted words are predicted and results checked at the rising edge.
  always @(posedge clk_i) begin : observe
    bit want;
    bit got_word;
    bit lvl_out;
    if (!rst_ni) begin
      level_taken  <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      level_taken  <= in_valid_i && !in_stall_o;
      result_taken <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected word, out_level %0b", out_level_o));
        end else begin
          want = expected_levels.pop_front();
          if (out_level_o !== want)
            report_mismatch($sformatf("out_level %0b, expected %0b", out_level_o, want));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        lvl_out = tick_autorepeat(level_i, got_word);
        if (got_word) expected_levels.push_back(lvl_out);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_autorepeat(cfg_index_i, cfg_data_i);
        cfg_write_count++;
      end
    end
  end

  always @(negedge clk_i) begin : drive_levels
    if (rst_ni && (!in_valid_i || level_taken)) begin
      if (pending_levels.size() != 0 && idle_run >= pending_levels[0].gap &&
          !(pending_levels[0].drain_first && expected_levels.size() != 0)) begin
        level_i    <= pending_levels[0].level;
        in_valid_i <= 1'b1;
        idle_run   <= 0;
        void'(pending_levels.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        idle_run   <= idle_run + 1;
      end
    end
  end

  always @(negedge clk_i) begin : stall_results
    int unsigned wait_now;
    if (rst_ni) begin
      wait_now = result_taken ? idle_draw(rx_mode) : stall_left;
      out_stall_i <= (wait_now != 0);
      stall_left  <= (wait_now != 0) ? wait_now - 1 : 0;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic queue_run(input bit lvl, input int unsigned n, input bit force_drain);
    level_word_t w;
    for (int unsigned i = 0; i < n; i++) begin
      w.level       = lvl;
      w.gap         = idle_draw(tx_mode);
      w.drain_first = (force_drain && i == 0) || ($urandom_range(0, 63) == 0);
      pending_levels.push_back(w);
    end
  endtask

  // Waits until every word is in and out, then lets the pipeline empty.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (!(pending_levels.size() == 0 && (!in_valid_i || level_taken) &&
             expected_levels.size() == 0) && waited < SETTLE_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (waited >= SETTLE_LIMIT) begin
      report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
      expected_levels.delete();
    end
    repeat (PIPE_SLACK) @(negedge clk_i);
  endtask

  // Must be called at a falling edge; returns at the falling edge after the write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    int unsigned seen;
    seen = cfg_write_count;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (cfg_write_count == seen);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_stage(input logic [15:0] off_t,
                                                       input logic [15:0] on_t,
                                                       input logic [15:0] delay_t);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    w[DELAY_LSB +: 16] = delay_t;
    w[ON_LSB +: 16]    = on_t;
    w[OFF_LSB +: 16]   = off_t;
    return w;
  endfunction

  function automatic logic [15:0] draw_duration();
    case ($urandom_range(0, 9))
      6:       return 16'd0;
      7:       return 16'hFFFF;
      8:       return 16'($urandom_range(7, 40));
      9:       return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_stage_word();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'({$urandom, $urandom});
    return pack_stage(draw_duration(), draw_duration(), draw_duration());
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase_len;
    int unsigned phase_items;
    int unsigned h;
    int unsigned n;
    reset_autorepeat();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset timings: the very first sample passes even though it is a release.
    queue_run(1'b0, 2, 1'b0);
    queue_run(1'b1, 2, 1'b0);
    queue_run(1'b0, 1, 1'b0);
    settle();

    // Over-range stage count, one-tick stage 0, a stage with all-ones times.
    write_register(CFG_STAGE_COUNT, 48'd7);
    write_register(CFG_STAGE_BASE, pack_stage(16'd0, 16'd0, 16'd0));
    write_register(CFG_IDX_W'(CFG_STAGE_BASE + 1), pack_stage(16'd2, 16'd1, 16'd4));
    write_register(CFG_IDX_W'(CFG_STAGE_BASE + 2), {CFG_DATA_W{1'b1}});
    write_register(CFG_LAST_STAGE, pack_stage(16'd3, 16'd2, 16'd5));
    write_register(CFG_IDX_W'(CFG_LAST_STAGE + 1), {CFG_DATA_W{1'b1}});
    cfg_valid_i <= 1'b0;
    queue_run(1'b1, 12, 1'b0);
    settle();

    // Stage count dropped to zero while the key is still held and repeating.
    write_register(CFG_STAGE_COUNT, 48'd0);
    cfg_valid_i <= 1'b0;
    queue_run(1'b1, 5, 1'b0);
    queue_run(1'b0, 2, 1'b1);
    settle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 2) == 0)
          write_register(CFG_STAGE_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
        else
          write_register(CFG_STAGE_COUNT, CFG_DATA_W'($urandom_range(1, MAX_STAGES_DEF)));
      end
      for (int unsigned s = 0; s < MAX_STAGES_DEF; s++)
        if ($urandom_range(0, 1) == 0)
          write_register(CFG_IDX_W'(CFG_STAGE_BASE + s), draw_stage_word());
      if ($urandom_range(0, 7) == 0)
        write_register(CFG_IDX_W'($urandom_range(CFG_LAST_STAGE + 1, CFG_INDEX_TOP)),
                       draw_stage_word());
      cfg_valid_i <= 1'b0;

      phase_len   = $urandom_range(40, 160);
      phase_items = 0;
      while (phase_items < phase_len) begin
        if ($urandom_range(0, 7) != 0) begin
          h = $urandom_range(1, 60);
          n = $urandom_range(1, 8);
          queue_run(1'b1, h, 1'b0);
          queue_run(1'b0, n, 1'b0);
          phase_items += h + n;
        end else begin
          n = $urandom_range(1, 10);
          repeat (n) queue_run(1'($urandom_range(0, 1)), 1, 1'b0);
          phase_items += n;
        end
      end
      // Sometimes leave the key held so the next settings meet a running repeat.
      if ($urandom_range(0, 3) == 0) begin
        h = $urandom_range(1, 30);
        queue_run(1'b1, h, 1'b0);
        phase_items += h;
      end
      random_items += phase_items;
      settle();
    end

    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== button_autorepeat_generator_unit.f =====
+incdir+rtl
rtl/barg_pkg.sv
rtl/barg_cfg.sv
rtl/barg_engine.sv
rtl/button_autorepeat_generator_unit.sv
dv/testbench.sv
